[rtl/core/assert_macros.svh]
// Assertion macros for the RTL folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("assert failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assert failed");
`else
`define ASSERT_IMP(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/mas_pkg.sv]
// ----------------------------------------------------------------------------
// mas_pkg
// Types and constants for the masked attention softmax block.
// ----------------------------------------------------------------------------
`default_nettype none
package mas_pkg;
  localparam int ROW_MAX = 1024;

  localparam logic [2:0] CFG_SCALE  = 3'd0;
  localparam logic [2:0] CFG_CAUSAL = 3'd1;
  localparam logic [2:0] CFG_LWIN   = 3'd2;
  localparam logic [2:0] CFG_WSIZE  = 3'd3;
  localparam logic [2:0] CFG_RLEN   = 3'd4;
  localparam logic [2:0] CFG_QPH    = 3'd5;
  localparam logic [2:0] CFG_UMASK  = 3'd6;
  localparam logic [2:0] CFG_UBIAS  = 3'd7;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] score;
    logic signed [15:0] mask_value;
    logic signed [15:0] bias_value;
    logic [9:0]        query_index;
    logic              row_end;
  } in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        last_of_row;
  } out_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
      5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
      5'd15: v = 17'd34219; default: v = 17'd32768;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[rtl/core/masked_attention_softmax.sv]
// A load registers the scaled product, then stores the score; a closing load sums the exps.
// A drain forms the score's exp; the bit-serial divider (33 steps) then gives its result beat.
// One item at a time; in_stall is high while an item is worked on or a result waits.
// A shared exp unit (multiplier plus table interpolation) serves sum and drain.
// Synchronous active-low reset clears control state and configuration to defaults.
// ----------------------------------------------------------------------------
// masked_attention_softmax
// Softmax of one attention row with scaling, mask, bias, causal and window masking.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module masked_attention_softmax (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mas_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mas_pkg::out_t       out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_L1 = 4'd1, S_L2 = 4'd2, S_SRD = 4'd3,
                         S_SE1 = 4'd4, S_SE2 = 4'd5, S_DRD = 4'd6, S_DE1 = 4'd7,
                         S_DE2 = 4'd8, S_DDIV = 4'd9, S_OUT = 4'd10;

  logic [15:0] scale_r;
  logic causal_r, lwin_r, umask_r, ubias_r;
  logic [11:0] wsize_r;
  logic [10:0] rlen_r, qph_r;

  logic [3:0]  st_r;
  mas_pkg::in_t item_r;
  logic signed [15:0] max_r;
  logic [26:0] sum_r;
  logic [10:0] lcnt_r, dcnt_r, idx_r;
  logic        ready_r;
  logic signed [31:0] prod_r;
  logic [36:0] t_r;
  logic [15:0] mem [0:mas_pkg::ROW_MAX-1];
  logic signed [15:0] rd_r;
  logic [15:0] prob_r;
  logic        last_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd4096; causal_r <= 1'b0; lwin_r <= 1'b0; wsize_r <= '0;
      rlen_r <= 11'd1024; qph_r <= 11'd1024; umask_r <= 1'b0; ubias_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mas_pkg::CFG_SCALE:  scale_r  <= cfg_data;
        mas_pkg::CFG_CAUSAL: causal_r <= cfg_data[0];
        mas_pkg::CFG_LWIN:   lwin_r   <= cfg_data[0];
        mas_pkg::CFG_WSIZE:  wsize_r  <= cfg_data[11:0];
        mas_pkg::CFG_RLEN:   rlen_r   <= cfg_data[10:0];
        mas_pkg::CFG_QPH:    qph_r    <= cfg_data[10:0];
        mas_pkg::CFG_UMASK:  umask_r  <= cfg_data[0];
        mas_pkg::CFG_UBIAS:  ubias_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [10:0] eff_len;
  always_comb begin
    if (rlen_r == 11'd0) eff_len = 11'd1;
    else if (rlen_r > 11'd1024) eff_len = 11'd1024;
    else eff_len = rlen_r;
  end

  // load arithmetic on the registered product
  logic signed [32:0] p_rnd;
  logic signed [20:0] scaled;
  logic signed [21:0] xs;
  logic signed [15:0] xsat, xfin;
  logic [10:0] key;
  logic [11:0] real_q;
  logic masked;
  always_comb begin
    p_rnd  = {prod_r[31], prod_r} + 33'sd2048;
    scaled = p_rnd[32:12];
    xs = 22'(scaled)
       + (umask_r ? 22'(item_r.mask_value) : 22'sd0)
       + (ubias_r ? 22'(item_r.bias_value) : 22'sd0);
    if (xs > 22'sd32767) xsat = 16'sd32767;
    else if (xs < -22'sd32768) xsat = -16'sd32768;
    else xsat = xs[15:0];
    key    = ready_r ? 11'd0 : lcnt_r;
    real_q = {2'b0, item_r.query_index} + ((qph_r == rlen_r) ? 12'd0 : {1'b0, rlen_r});
    masked = (causal_r && (key > {1'b0, item_r.query_index})) ||
             (lwin_r && (real_q >= wsize_r) && ({1'b0, key} <= real_q - wsize_r));
    xfin = masked ? -16'sd32768 : xsat;
  end

  // shared exp unit: t = u*94548 registered, then table interpolation
  logic [4:0]  ek;
  logic [19:0] er;
  logic [16:0] ta, tb, ev;
  logic [37:0] dm;
  logic [16:0] esh;
  logic [16:0] half;
  always_comb begin
    ek   = {1'b0, t_r[23:20]};
    er   = t_r[19:0];
    ta   = mas_pkg::pow2_tab(ek);
    tb   = mas_pkg::pow2_tab(ek + 5'd1);
    dm   = 38'(ta - tb) * 38'(er);
    ev   = ta - 17'(dm >> 20);
    half = 17'((18'd1 << t_r[28:24]) >> 1);
    esh  = (t_r[36:24] >= 13'd17) ? 17'd0 : 17'((18'(ev) + 18'(half)) >> t_r[28:24]);
  end
  logic [15:0] u_val;
  assign u_val = 16'(max_r - rd_r);

  logic        div_start, div_done;
  logic [16:0] div_q;
  mas_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({esh, 16'd0} + 33'(sum_r >> 1)), .den(sum_r),
    .done(div_done), .quo(div_q)
  );
  assign div_start = (st_r == S_DE2);

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (st_r == S_L2) mem[key[9:0]] <= xfin;
    rd_r <= mem[idx_r[9:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; max_r <= -16'sd32768; sum_r <= '0;
      lcnt_r <= '0; dcnt_r <= '0; ready_r <= 1'b0; idx_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (in_acc) begin
          item_r <= in_data;
          if (!in_data.mode) st_r <= S_L1;
          else if (ready_r) begin
            idx_r <= dcnt_r;
            st_r  <= S_DRD;
          end
        end
        S_L1: begin
          prod_r <= 32'(item_r.score) * $signed({1'b0, scale_r});
          st_r   <= S_L2;
        end
        S_L2: begin
          if (ready_r) begin
            ready_r <= 1'b0; dcnt_r <= '0;
          end
          if (ready_r || xfin > max_r) max_r <= xfin;
          lcnt_r <= key + 11'd1;
          if (item_r.row_end || (key + 11'd1 >= eff_len)) begin
            sum_r <= '0; idx_r <= '0; st_r <= S_SRD;
          end else st_r <= S_IDLE;
        end
        S_SRD: st_r <= S_SE1;
        S_SE1: begin
          t_r  <= 37'(u_val) * 37'd94548;
          idx_r <= idx_r + 11'd1;
          st_r <= S_SE2;
        end
        S_SE2: begin
          sum_r <= sum_r + 27'(esh);
          if (idx_r >= lcnt_r) begin
            dcnt_r <= '0; ready_r <= 1'b1; st_r <= S_IDLE;
          end else st_r <= S_SE1;
        end
        S_DRD: st_r <= S_DE1;
        S_DE1: begin
          t_r  <= 37'(u_val) * 37'd94548;
          st_r <= S_DE2;
        end
        S_DE2: st_r <= S_DDIV;
        S_DDIV: if (div_done) begin
          prob_r <= (div_q > 17'd65535) ? 16'hFFFF : div_q[15:0];
          last_r <= (dcnt_r + 11'd1 >= lcnt_r);
          if (dcnt_r + 11'd1 >= lcnt_r) begin
            ready_r <= 1'b0; max_r <= -16'sd32768; sum_r <= '0;
            lcnt_r <= '0; dcnt_r <= '0;
          end else dcnt_r <= dcnt_r + 11'd1;
          st_r <= S_OUT;
        end
        S_OUT: if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (st_r == S_OUT);
  assign out_data  = '{probability: prob_r, last_of_row: last_r};

  `ASSERT_IMP(a_stall_busy, clk, rst_n, !(out_valid && !in_stall))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_IMP(a_cnt_range, clk, rst_n, lcnt_r <= 11'd1024)
endmodule
`default_nettype wire

[rtl/core/mas_div.sv]
// ----------------------------------------------------------------------------
// mas_div
// Radix-2 restoring divider: 33-bit dividend by 27-bit divisor, 17-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module mas_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] num,
  input  wire logic [26:0] den,
  output logic             done,
  output logic [16:0]      quo
);
  logic [27:0] rem_r, rem_nxt;
  logic [32:0] num_r;
  logic [16:0] quo_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [27:0] trial;
  logic        q_ok;

  // quotient is known below 2^17, so only its low 17 bits are kept
  always_comb begin
    trial   = {rem_r[26:0], num_r[32]};
    q_ok    = trial >= {1'b0, den};
    rem_nxt = q_ok ? trial - {1'b0, den} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd33;
      rem_r  <= '0;
      num_r  <= num;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[31:0], 1'b0};
      quo_r <= {quo_r[15:0], q_ok};
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  assign done = busy_r && (cnt_r == 6'd1);
  always_comb quo = {quo_r[15:0], q_ok};
endmodule
`default_nettype wire
